// ===== sv/rmutex_pkg.sv =====
`default_nettype none

package rmutex_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int LEVEL_W  = 16;

  // requested operation
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOCK    = 2'd0,
    FUNC_TRYLOCK = 2'd1,
    FUNC_UNLOCK  = 2'd2
  } func_t;

  // answer codes
  typedef enum logic [STATUS_W-1:0] {
    STS_ACQUIRED    = 3'd0,
    STS_BUSY        = 3'd1,
    STS_BLOCKED     = 3'd2,
    STS_RELEASED    = 3'd3,
    STS_STILL_HELD  = 3'd4,
    STS_UNLOCK_FREE = 3'd5,
    STS_QUEUE_FULL  = 3'd6,
    STS_COUNT_OVF   = 3'd7
  } status_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // one result transaction
  typedef struct packed {
    status_t             status;
    logic                woken_valid;
    logic [TID_W-1:0]    woken_thread;
    logic [LEVEL_W-1:0]  hold_level;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/recursive_mutex_with_fifo_waiters.sv =====
// A request is captured together with the read of the waiter queue RAM head
// entry, decided in ST_EXEC once the output register can take a result, and its
// result transaction is then registered in the output register. Requests are
// taken one at a time: the input stalls until the decision and write-back.
// Reset: synchronous; lock state, queue pointers, mode and output valid clear.
// Queue RAM contents are not cleared and need no clearing pass.
`default_nettype none

module recursive_mutex_with_fifo_waiters #(
  parameter int QUEUE_DEPTH = rmutex_pkg::QUEUE_DEPTH_DEF,
  parameter int COUNT_BITS  = rmutex_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic                              recursive_mode,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [rmutex_pkg::FUNC_W-1:0]     func,
  input  wire logic [rmutex_pkg::TID_W-1:0]      thread_id,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [rmutex_pkg::STATUS_W-1:0]   status,
  output      logic                              woken_valid,
  output      logic [rmutex_pkg::TID_W-1:0]      woken_thread,
  output      logic [rmutex_pkg::LEVEL_W-1:0]    hold_level
);

  logic                 res_ready;
  logic                 res_valid;
  rmutex_pkg::result_t  res;
  rmutex_pkg::result_t  out_res;

  assign cfg_ready = 1'b1;

  // output register may take a new result when empty or draining
  assign res_ready = !out_valid || !out_stall;

  rmutex_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (recursive_mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .thread_id (thread_id),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign status       = out_res.status;
  assign woken_valid  = out_res.woken_valid;
  assign woken_thread = out_res.woken_thread;
  assign hold_level   = out_res.hold_level;

`ifndef NO_ASSERTIONS
  // a taken request blocks the input for its decision cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in progress");

  // a new result never overwrites a held, stalled result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || !out_stall))
    else $error("result overwrote pending output");

  // a woken waiter only comes with a full release
  a_wake_on_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && woken_valid) |-> (status == rmutex_pkg::STS_RELEASED))
    else $error("waiter woken without release");

  // results only follow a request
  a_result_after_request: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("result produced outside decision cycle");
`endif

endmodule

`default_nettype wire

// ===== sv/rmutex_ram.sv =====
`default_nettype none

module rmutex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rmutex_core.sv =====
`default_nettype none

module rmutex_core #(
  parameter int QUEUE_DEPTH = rmutex_pkg::QUEUE_DEPTH_DEF,
  parameter int COUNT_BITS  = rmutex_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [rmutex_pkg::FUNC_W-1:0]  func,
  input  wire logic [rmutex_pkg::TID_W-1:0]   thread_id,
  input  wire logic                           res_ready,
  output      logic                           res_valid,
  output      rmutex_pkg::result_t            res
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rmutex_pkg::state_t state, state_next;

  logic                           recursive_mode;
  logic [rmutex_pkg::FUNC_W-1:0]  func_q;
  logic [rmutex_pkg::TID_W-1:0]   tid_q;

  logic [COUNT_BITS-1:0]          hold_count, hold_count_next;
  logic [rmutex_pkg::TID_W-1:0]   owner_id, owner_id_next;
  logic                           owner_valid, owner_valid_next;
  logic [PTR_W-1:0]               queue_head, queue_head_next;
  logic [PTR_W-1:0]               queue_tail, queue_tail_next;
  logic [CNT_W-1:0]               queue_count, queue_count_next;

  logic                           accept;
  logic                           ram_we;
  logic [rmutex_pkg::TID_W-1:0]   ram_rdata;
  logic                           relock;
  logic [31:0]                    level_ext;

  assign accept   = in_valid && (state == rmutex_pkg::ST_IDLE);
  assign in_stall = (state != rmutex_pkg::ST_IDLE);

  // waiter queue storage, head entry is read when a request is taken
  rmutex_ram #(
    .WIDTH (rmutex_pkg::TID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (queue_tail),
    .wdata (tid_q),
    .re    (accept),
    .raddr (queue_head),
    .rdata (ram_rdata)
  );

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      recursive_mode <= 1'b0;
    end else if (cfg_we) begin
      recursive_mode <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      tid_q  <= thread_id;
    end
  end

  // state and lock registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rmutex_pkg::ST_IDLE;
      hold_count  <= '0;
      owner_id    <= '0;
      owner_valid <= 1'b0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
    end else begin
      state       <= state_next;
      hold_count  <= hold_count_next;
      owner_id    <= owner_id_next;
      owner_valid <= owner_valid_next;
      queue_head  <= queue_head_next;
      queue_tail  <= queue_tail_next;
      queue_count <= queue_count_next;
    end
  end

  assign relock = recursive_mode && owner_valid && (owner_id == tid_q);

  // read-modify-write of the lock state
  always_comb begin
    state_next       = state;
    hold_count_next  = hold_count;
    owner_id_next    = owner_id;
    owner_valid_next = owner_valid;
    queue_head_next  = queue_head;
    queue_tail_next  = queue_tail;
    queue_count_next = queue_count;
    ram_we           = 1'b0;
    res_valid        = 1'b0;
    res.status       = rmutex_pkg::STS_ACQUIRED;
    res.woken_valid  = 1'b0;
    res.woken_thread = '0;

    unique case (state)
      rmutex_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = rmutex_pkg::ST_EXEC;
        end
      end
      rmutex_pkg::ST_EXEC: begin
        case (func_q) inside
          rmutex_pkg::FUNC_LOCK, rmutex_pkg::FUNC_TRYLOCK: begin
            if (res_ready) begin
              res_valid  = 1'b1;
              state_next = rmutex_pkg::ST_IDLE;
              if (relock) begin
                if (hold_count == '1) begin
                  res.status = rmutex_pkg::STS_COUNT_OVF;
                end else begin
                  hold_count_next = hold_count + COUNT_BITS'(1);
                end
              end else if (hold_count == '0) begin
                owner_id_next    = tid_q;
                owner_valid_next = 1'b1;
                hold_count_next  = COUNT_BITS'(1);
              end else if (func_q == rmutex_pkg::FUNC_TRYLOCK) begin
                res.status = rmutex_pkg::STS_BUSY;
              end else if (queue_count == CNT_W'(QUEUE_DEPTH)) begin
                res.status = rmutex_pkg::STS_QUEUE_FULL;
              end else begin
                ram_we           = 1'b1;
                queue_tail_next  = (queue_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                   : queue_tail + PTR_W'(1);
                queue_count_next = queue_count + CNT_W'(1);
                res.status       = rmutex_pkg::STS_BLOCKED;
              end
            end
          end
          rmutex_pkg::FUNC_UNLOCK: begin
            if (res_ready) begin
              res_valid  = 1'b1;
              state_next = rmutex_pkg::ST_IDLE;
              if (hold_count == '0) begin
                res.status = rmutex_pkg::STS_UNLOCK_FREE;
              end else begin
                hold_count_next = hold_count - COUNT_BITS'(1);
                if (hold_count == COUNT_BITS'(1)) begin
                  owner_id_next    = '0;
                  owner_valid_next = 1'b0;
                  res.status       = rmutex_pkg::STS_RELEASED;
                  // hand the head waiter back for a retry
                  if (queue_count != '0) begin
                    res.woken_valid  = 1'b1;
                    res.woken_thread = ram_rdata;
                    queue_head_next  = (queue_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                       : queue_head + PTR_W'(1);
                    queue_count_next = queue_count - CNT_W'(1);
                  end
                end else begin
                  res.status = rmutex_pkg::STS_STILL_HELD;
                end
              end
            end
          end
          default: begin
            // unused code: no change, no result
            state_next = rmutex_pkg::ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = rmutex_pkg::ST_IDLE;
      end
    endcase

    level_ext      = 32'(hold_count_next);
    res.hold_level = level_ext[rmutex_pkg::LEVEL_W-1:0];
  end

endmodule

`default_nettype wire
